// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/cnlc_pkg.sv =====
// ----------------------------------------------------------------------------
// cnlc_pkg
// Shared widths, constants and controller/datapath types of the mod-10
// card number check block.
// ----------------------------------------------------------------------------
package cnlc_pkg;

	localparam int ACC_W          = 63;
	localparam int CNT_W          = 5;
	localparam int KIND_W         = 2;
	localparam int DIGIT_W        = 4;
	localparam int MAX_DIGITS_DEF = 19;

	localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_3X   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_5X   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_4X   = 2'd3;

	// leading digit pairs and lengths that select a kind
	localparam logic [DIGIT_W-1:0] LEAD_3     = 4'd3;
	localparam logic [DIGIT_W-1:0] SEC_4      = 4'd4;
	localparam logic [DIGIT_W-1:0] SEC_7      = 4'd7;
	localparam logic [DIGIT_W-1:0] LEAD_5     = 4'd5;
	localparam logic [DIGIT_W-1:0] SEC_LO_5X  = 4'd1;
	localparam logic [DIGIT_W-1:0] SEC_HI_5X  = 4'd5;
	localparam logic [DIGIT_W-1:0] LEAD_4     = 4'd4;
	localparam logic [CNT_W-1:0]   LEN_3X     = 5'd15;
	localparam logic [CNT_W-1:0]   LEN_5X     = 5'd16;
	localparam logic [CNT_W-1:0]   LEN_4X_A   = 5'd13;
	localparam logic [CNT_W-1:0]   LEN_4X_B   = 5'd16;
	localparam logic [CNT_W-1:0]   MAX_COUNT  = 5'd19;

	localparam int RADIX = 10;

	typedef struct packed {
		logic load;
		logic est_a;
		logic est_b;
		logic step;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic last;
	} sts_t;

endpackage

// ===== hw/rtl/cnlc_ctrl.sv =====
// ----------------------------------------------------------------------------
// cnlc_ctrl
// Sequencer: three passes of the divide-by-ten unit per digit, then a
// hand-off into the output register.
// ----------------------------------------------------------------------------
module cnlc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  cnlc_pkg::sts_t sts,
	output cnlc_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EST_A,
		ST_EST_B,
		ST_STEP,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	assign cmd.load    = (state_q == ST_IDLE) && in_valid;
	assign cmd.est_a   = (state_q == ST_EST_A);
	assign cmd.est_b   = (state_q == ST_EST_B);
	assign cmd.step    = (state_q == ST_STEP);
	assign cmd.publish = (state_q == ST_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EST_A;
				end
				ST_EST_A: state_q <= ST_EST_B;
				ST_EST_B: state_q <= ST_STEP;
				ST_STEP: begin
					state_q <= sts.last ? ST_DONE : ST_EST_A;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/cnlc_dp.sv =====
// ----------------------------------------------------------------------------
// cnlc_dp
// Datapath: shift-add divide-by-ten unit, running mod-10 digit sum, digit
// count, leading pair tracking and the output register.
// ----------------------------------------------------------------------------
module cnlc_dp #(
	parameter int MAX_DIGITS = cnlc_pkg::MAX_DIGITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cnlc_pkg::cmd_t               cmd,
	output cnlc_pkg::sts_t               sts,
	input  logic [cnlc_pkg::ACC_W-1:0]   account_number,
	output logic                         check_passed,
	output logic [cnlc_pkg::KIND_W-1:0]  card_kind,
	output logic [cnlc_pkg::CNT_W-1:0]   digit_count
);

	localparam int ACC_W   = cnlc_pkg::ACC_W;
	localparam int CNT_W   = cnlc_pkg::CNT_W;
	localparam int KIND_W  = cnlc_pkg::KIND_W;
	localparam int DIGIT_W = cnlc_pkg::DIGIT_W;
	localparam int POS_W   = $clog2(MAX_DIGITS);

	logic [ACC_W-1:0]   rest_q;
	logic [ACC_W-1:0]   est_q;
	logic [POS_W-1:0]   pos_q;
	logic [DIGIT_W-1:0] tmod_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIGIT_W-1:0] hi_q;
	logic [DIGIT_W-1:0] lo_q;
	logic [DIGIT_W-1:0] prev_q;

	logic               passed_q;
	logic [KIND_W-1:0]  kind_q;
	logic [CNT_W-1:0]   count_q;

	// quotient estimate, split over the two estimate passes
	logic [ACC_W-1:0] q1, q2, q3, q4, q5;
	logic [ACC_W-1:0] qe, qc, rem;
	logic [4:0]       r5;
	logic             fix;
	logic [DIGIT_W-1:0] dig;
	logic [4:0]       dbl, contrib, msum;
	logic [DIGIT_W-1:0] tmod_next;
	logic [KIND_W-1:0] kind_sel;

	always_comb begin
		q1 = (rest_q >> 1) + (rest_q >> 2);
		q2 = q1 + (q1 >> 4);
		q3 = q2 + (q2 >> 8);
		q4 = est_q + (est_q >> 16);
		q5 = q4 + (q4 >> 32);
	end

	// final pass: truncate estimate, remainder, single correction
	always_comb begin
		qe  = est_q >> 3;
		rem = rest_q - ((qe << 3) + (qe << 1));
		r5  = rem[4:0];
		fix = (r5 > 5'(cnlc_pkg::RADIX - 1));
		qc  = qe + ACC_W'(fix);
		dig = fix ? DIGIT_W'(r5 - 5'(cnlc_pkg::RADIX)) : r5[DIGIT_W-1:0];
	end

	// odd positions: double, then add the two decimal digits
	always_comb begin
		dbl = {dig, 1'b0};
		if (pos_q[0]) begin
			contrib = (dbl >= 5'(cnlc_pkg::RADIX)) ? dbl - 5'(cnlc_pkg::RADIX - 1) : dbl;
		end else begin
			contrib = {1'b0, dig};
		end
		msum      = {1'b0, tmod_q} + contrib;
		tmod_next = (msum >= 5'(cnlc_pkg::RADIX)) ? DIGIT_W'(msum - 5'(cnlc_pkg::RADIX))
		                                           : msum[DIGIT_W-1:0];
	end

	assign sts.last = (rest_q < ACC_W'(cnlc_pkg::RADIX)) ||
	                  (pos_q == POS_W'(MAX_DIGITS - 1));

	always_comb begin
		if (tmod_q != '0) begin
			kind_sel = cnlc_pkg::KIND_NONE;
		end else if (hi_q == cnlc_pkg::LEAD_3 &&
		             (lo_q == cnlc_pkg::SEC_4 || lo_q == cnlc_pkg::SEC_7) &&
		             cnt_q == cnlc_pkg::LEN_3X) begin
			kind_sel = cnlc_pkg::KIND_3X;
		end else if (hi_q == cnlc_pkg::LEAD_5 && lo_q >= cnlc_pkg::SEC_LO_5X &&
		             lo_q <= cnlc_pkg::SEC_HI_5X && cnt_q == cnlc_pkg::LEN_5X) begin
			kind_sel = cnlc_pkg::KIND_5X;
		end else if (hi_q == cnlc_pkg::LEAD_4 &&
		             (cnt_q == cnlc_pkg::LEN_4X_A || cnt_q == cnlc_pkg::LEN_4X_B)) begin
			kind_sel = cnlc_pkg::KIND_4X;
		end else begin
			kind_sel = cnlc_pkg::KIND_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q   <= '0;
			est_q    <= '0;
			pos_q    <= '0;
			tmod_q   <= '0;
			cnt_q    <= '0;
			hi_q     <= '0;
			lo_q     <= '0;
			prev_q   <= '0;
			passed_q <= 1'b0;
			kind_q   <= '0;
			count_q  <= '0;
		end else begin
			if (cmd.load) begin
				rest_q <= account_number;
				pos_q  <= '0;
				tmod_q <= '0;
				cnt_q  <= CNT_W'(1);
				hi_q   <= '0;
				lo_q   <= '0;
				prev_q <= '0;
			end
			if (cmd.est_a) est_q <= q3;
			if (cmd.est_b) est_q <= q5;
			if (cmd.step) begin
				rest_q <= qc;
				pos_q  <= pos_q + POS_W'(1);
				tmod_q <= tmod_next;
				prev_q <= dig;
				if (dig != '0) begin
					cnt_q <= CNT_W'(pos_q) + CNT_W'(1);
					hi_q  <= dig;
					lo_q  <= prev_q;
				end
			end
			if (cmd.publish) begin
				passed_q <= (tmod_q == '0);
				kind_q   <= kind_sel;
				count_q  <= cnt_q;
			end
		end
	end

	assign check_passed = passed_q;
	assign card_kind    = kind_q;
	assign digit_count  = count_q;

endmodule

// ===== hw/rtl/card_number_luhn_classify_core.sv =====
// ----------------------------------------------------------------------------
// card_number_luhn_classify_core
// Mod-10 digit check of a binary account number with digit count and
// card kind from the leading digits.
//
//   channel  signals                       payload
//   in       in_valid / in_stall           account_number
//   out      out_valid / out_stall         check_passed, card_kind, digit_count
//
// each digit examined (1 .. MAX_DIGITS of them) takes three passes of the
// divide-by-ten unit; a hand-off into the output register follows the last.
// one item at a time; the finished result sits in the output register and
// a new item may be taken while it waits to be read.
// reset needs no clearing pass; the block is ready the cycle after reset.
// ----------------------------------------------------------------------------
module card_number_luhn_classify_core #(
	parameter int MAX_DIGITS = cnlc_pkg::MAX_DIGITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [cnlc_pkg::ACC_W-1:0]  account_number,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        check_passed,
	output logic [cnlc_pkg::KIND_W-1:0] card_kind,
	output logic [cnlc_pkg::CNT_W-1:0]  digit_count
);

	cnlc_pkg::cmd_t cmd;
	cnlc_pkg::sts_t sts;

	cnlc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	cnlc_dp #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.account_number (account_number),
		.check_passed   (check_passed),
		.card_kind      (card_kind),
		.digit_count    (digit_count)
	);

endmodule

// ===== hw/rtl/cnlc_checker.sv =====
// ----------------------------------------------------------------------------
// cnlc_checker
// Port-level checks of the mod-10 card number block, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cnlc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        check_passed,
	input logic [cnlc_pkg::KIND_W-1:0] card_kind,
	input logic [cnlc_pkg::CNT_W-1:0]  digit_count
);

	// a stalled result stays put
	`ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(card_kind) && $stable(digit_count) && $stable(check_passed),
		"stalled result changed")

	// an item in work blocks the input
	`ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall,
		"input taken while busy")

	// any kind implies a passing check
	`ASSERT_IMP(a_kind_needs_pass, clk, arst_n,
		out_valid && card_kind != cnlc_pkg::KIND_NONE, check_passed,
		"kind set on failed check")

	// kind 2 only with sixteen digits
	`ASSERT_IMP(a_kind_5x_len, clk, arst_n,
		out_valid && card_kind == cnlc_pkg::KIND_5X, digit_count == cnlc_pkg::LEN_5X,
		"kind 2 with wrong length")

endmodule

bind card_number_luhn_classify_core cnlc_checker u_cnlc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.check_passed (check_passed),
	.card_kind    (card_kind),
	.digit_count  (digit_count)
);

// ===== sim/tb_card_number_luhn_classify_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_card_number_luhn_classify_core
// Self-checking bench for the mod-10 card number check. A queue of account
// numbers (directed corner values, well-formed card numbers, near misses,
// broken check digits and raw random values) feeds a clocked driver. A clocked
// monitor compares every result with a local digit-by-digit prediction.
// Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_card_number_luhn_classify_core;

	localparam int ACC_W      = cnlc_pkg::ACC_W;
	localparam int CNT_W      = cnlc_pkg::CNT_W;
	localparam int KIND_W     = cnlc_pkg::KIND_W;
	localparam int N_RANDOM   = 1000;
	localparam int QUIET_TAIL = 150;
	localparam int STUCK_MAX  = 2000;
	localparam int DRAIN_CYC  = 80;

	typedef struct packed {
		logic              check_passed;
		logic [KIND_W-1:0] card_kind;
		logic [CNT_W-1:0]  digit_count;
	} luhn_res_t;

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              in_valid       = 1'b0;
	logic              in_stall;
	logic [ACC_W-1:0]  account_number = '0;
	logic              out_valid;
	logic              out_stall      = 1'b0;
	logic              check_passed;
	logic [KIND_W-1:0] card_kind;
	logic [CNT_W-1:0]  digit_count;

	logic [ACC_W-1:0] pending_numbers[$];
	luhn_res_t        expected_results[$];

	int n_total;
	int acc_in;
	int acc_out;
	int errors;
	int n_passed;
	int kind_cnt[4];
	int in_gap;
	int out_gap;
	int stuck;

	card_number_luhn_classify_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.account_number (account_number),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.check_passed   (check_passed),
		.card_kind      (card_kind),
		.digit_count    (digit_count)
	);

	always #1 clk = ~clk;

	// every 63-bit value has at most 19 digits, so nothing is dropped at the default size
	function automatic luhn_res_t predict_luhn(input logic [ACC_W-1:0] acct);
		luhn_res_t       r;
		longint unsigned rest;
		longint unsigned lead;
		int unsigned     total;
		int unsigned     pos;
		int unsigned     d;
		int unsigned     dd;
		rest  = {1'b0, acct};
		total = 0;
		pos   = 0;
		while (rest != 0) begin
			d = 32'(rest % 10);
			if (pos % 2 == 0) begin
				total += d;
			end else begin
				dd = 2 * d;
				total += dd / 10 + dd % 10;
			end
			rest = rest / 10;
			pos++;
		end
		r.digit_count  = (pos == 0) ? 5'd1 : pos[CNT_W-1:0];
		r.check_passed = (total % 10 == 0);
		lead = {1'b0, acct};
		while (lead >= 100) lead = lead / 10;
		r.card_kind = cnlc_pkg::KIND_NONE;
		if ((lead == 34 || lead == 37) && r.digit_count == 15)
			r.card_kind = cnlc_pkg::KIND_3X;
		else if (lead >= 51 && lead <= 55 && r.digit_count == 16)
			r.card_kind = cnlc_pkg::KIND_5X;
		else if (lead / 10 == 4 && (r.digit_count == 13 || r.digit_count == 16))
			r.card_kind = cnlc_pkg::KIND_4X;
		if (!r.check_passed)
			r.card_kind = cnlc_pkg::KIND_NONE;
		return r;
	endfunction

	// prefix, random body, then the one check digit that passes (or a wrong one)
	function automatic logic [ACC_W-1:0] make_card(input int unsigned pfx, input int pfx_len,
			input int len, input bit broken);
		longint unsigned body;
		longint unsigned cand;
		int unsigned     k;
		body = pfx;
		cand = 0;
		k    = $urandom_range(1, 9);
		for (int i = pfx_len; i < len - 1; i++)
			body = body * 10 + $urandom_range(0, 9);
		for (int d = 0; d < 10; d++)
			if (predict_luhn(ACC_W'(body * 10 + d)).check_passed)
				cand = body * 10 + d;
		if (broken)
			cand = body * 10 + ((cand % 10) + k) % 10;
		return cand[ACC_W-1:0];
	endfunction

	function automatic logic [ACC_W-1:0] pick_number();
		int unsigned     sel;
		int unsigned     lens5[2];
		longint unsigned p10;
		logic [63:0]     raw;
		sel      = $urandom_range(0, 99);
		lens5[0] = 15;
		lens5[1] = 17;
		raw      = {$urandom, $urandom};
		p10      = 1;
		if (sel < 40) begin
			case ($urandom_range(0, 3))
				0: return make_card($urandom_range(0, 1) ? 34 : 37, 2, 15, 1'b0);
				1: return make_card($urandom_range(51, 55), 2, 16, 1'b0);
				2: return make_card(4, 1, 13, 1'b0);
				default: return make_card(4, 1, 16, 1'b0);
			endcase
		end else if (sel < 55) begin
			// near misses: right prefix with wrong length, or a prefix just outside; some draws still form a valid card
			case ($urandom_range(0, 4))
				0: return make_card($urandom_range(0, 1) ? 34 : 37, 2,
					$urandom_range(0, 1) ? 14 : 16, 1'b0);
				1: return make_card($urandom_range(51, 55), 2, lens5[$urandom_range(0, 1)], 1'b0);
				2: return make_card(4, 1, $urandom_range(12, 18), 1'b0);
				3: return make_card($urandom_range(0, 1) ? 50 : 56, 2, 16, 1'b0);
				default: return make_card($urandom_range(30, 39), 2, 15, 1'b0);
			endcase
		end else if (sel < 65) begin
			case ($urandom_range(0, 2))
				0: return make_card($urandom_range(0, 1) ? 34 : 37, 2, 15, 1'b1);
				1: return make_card($urandom_range(51, 55), 2, 16, 1'b1);
				default: return make_card(4, 1, $urandom_range(0, 1) ? 13 : 16, 1'b1);
			endcase
		end else if (sel < 85) begin
			return raw[ACC_W-1:0] >> $urandom_range(0, ACC_W - 1);
		end else if (sel < 93) begin
			// values around a power of ten
			for (int i = $urandom_range(1, 18); i > 0; i--) p10 = p10 * 10;
			return ACC_W'(p10 - 1 + $urandom_range(0, 1));
		end
		return raw[ACC_W-1:0];
	endfunction

	// quiet stretches: one third of the run in chunks, and the tail
	function automatic bit quiet_now();
		return (acc_in >= n_total - QUIET_TAIL) || ((acc_in / 100) % 3 == 2);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid       <= 1'b0;
			account_number <= '0;
			in_gap         <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(predict_luhn(account_number));
				acc_in <= acc_in + 1;
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap   <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_numbers.size() == 0) begin
					in_valid <= 1'b0;
				end else if (!quiet_now() && $urandom_range(0, 9) == 0) begin
					in_gap   <= $urandom_range(0, 7);
					in_valid <= 1'b0;
				end else begin
					in_valid       <= 1'b1;
					account_number <= pending_numbers.pop_front();
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		luhn_res_t exp_r;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap   <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				acc_out <= acc_out + 1;
				if (expected_results.size() == 0) begin
					$display("%t unexpected item: passed=%0d kind=%0d count=%0d", $time,
						check_passed, card_kind, digit_count);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (check_passed !== exp_r.check_passed) begin
						$display("%t check_passed mismatch: expected %0d, actual %0d", $time,
							exp_r.check_passed, check_passed);
						errors++;
					end
					if (card_kind !== exp_r.card_kind) begin
						$display("%t card_kind mismatch: expected %0d, actual %0d", $time,
							exp_r.card_kind, card_kind);
						errors++;
					end
					if (digit_count !== exp_r.digit_count) begin
						$display("%t digit_count mismatch: expected %0d, actual %0d", $time,
							exp_r.digit_count, digit_count);
						errors++;
					end
					n_passed += exp_r.check_passed;
					kind_cnt[exp_r.card_kind]++;
				end
			end
			if (out_gap > 0) begin
				out_gap   <= out_gap - 1;
				out_stall <= 1'b1;
			end else if (!quiet_now() && $urandom_range(0, 11) == 0) begin
				out_gap   <= $urandom_range(0, 7);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck <= 0;
		end else begin
			stuck <= stuck + 1;
			if (stuck == STUCK_MAX) begin
				$display("%t watchdog: no progress, %0d items still expected", $time,
					expected_results.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [ACC_W-1:0] all_ones;
		all_ones = '1;
		// directed corners
		pending_numbers.push_back('0);
		pending_numbers.push_back(63'd1);
		pending_numbers.push_back(63'd9);
		pending_numbers.push_back(63'd10);
		pending_numbers.push_back(63'd18);
		pending_numbers.push_back(63'd99);
		pending_numbers.push_back(63'd100);
		pending_numbers.push_back(all_ones);
		pending_numbers.push_back(63'h5555_5555_5555_5555);
		pending_numbers.push_back(63'h2aaa_aaaa_aaaa_aaaa);
		pending_numbers.push_back(63'd999999999999999999);
		pending_numbers.push_back(63'd1000000000000000000);
		pending_numbers.push_back(63'd1000000000000);
		pending_numbers.push_back(make_card(34, 2, 15, 1'b0));
		pending_numbers.push_back(make_card(37, 2, 15, 1'b0));
		pending_numbers.push_back(make_card(51, 2, 16, 1'b0));
		pending_numbers.push_back(make_card(55, 2, 16, 1'b0));
		pending_numbers.push_back(make_card(4, 1, 13, 1'b0));
		pending_numbers.push_back(make_card(4, 1, 16, 1'b0));
		pending_numbers.push_back(make_card(4, 1, 14, 1'b0));
		pending_numbers.push_back(make_card(34, 2, 16, 1'b0));
		pending_numbers.push_back(make_card(56, 2, 16, 1'b0));
		pending_numbers.push_back(make_card(50, 2, 16, 1'b0));
		pending_numbers.push_back(make_card(37, 2, 15, 1'b1));
		pending_numbers.push_back(make_card(4, 1, 16, 1'b1));
		for (int i = 0; i < N_RANDOM; i++)
			pending_numbers.push_back(pick_number());
		n_total = pending_numbers.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_numbers.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (expected_results.size() != 0) begin
			$display("%t %0d expected items never arrived", $time, expected_results.size());
			errors++;
		end
		$display("checked %0d account numbers (%0d results), %0d passing the digit check",
			acc_in, acc_out, n_passed);
		$display("kinds seen: none %0d, 3x %0d, 5x %0d, 4x %0d",
			kind_cnt[cnlc_pkg::KIND_NONE], kind_cnt[cnlc_pkg::KIND_3X],
			kind_cnt[cnlc_pkg::KIND_5X], kind_cnt[cnlc_pkg::KIND_4X]);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/cnlc_pkg.sv
hw/rtl/cnlc_ctrl.sv
hw/rtl/cnlc_dp.sv
hw/rtl/card_number_luhn_classify_core.sv
hw/rtl/cnlc_checker.sv
sim/tb_card_number_luhn_classify_core.sv
